@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; each use expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/srpt_pkg.sv @@
// Shared types and constants of the SRPT scheduler.
// No dependencies; imported by all but the RAM and macros.
package srpt_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 128;
   localparam int KEY_W               = 20;
   localparam int TAG_W               = 16;
   localparam int TIME_W              = 32;
   localparam int COUNT_OUT_W         = 8;
   localparam int STATUS_W            = 2;

   localparam logic [KEY_W-1:0] REM_MAX = '1;

   typedef enum logic {
      OP_ARRIVE   = 1'b0,
      OP_COMPLETE = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_IDLE_DONE = 2'd2
   } status_type;

   // One queued job: remaining time is the sort key.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Request from the decision logic to the queue engine.
   typedef struct packed {
      logic      start;
      logic      pop;
      entry_type entry;
   } qcmd_type;

   // Report from the queue engine.
   typedef struct packed {
      logic      done;
      entry_type head;
   } qstat_type;

endpackage

@@ src/srpt_chan_if.sv @@
// Valid/ready channel interfaces for scheduler events and results.
// Depends on srpt_pkg for field widths.
interface srpt_req_if import srpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [TIME_W-1:0] now;
   logic [KEY_W-1:0]  job_size;
   logic [TAG_W-1:0]  job_tag;

   modport source (output valid, output opcode, output now, output job_size,
                   output job_tag, input ready);
   modport sink   (input valid, input opcode, input now, input job_size,
                   input job_tag, output ready);
endinterface

interface srpt_rsp_if import srpt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   busy_res;
   logic [TAG_W-1:0]       running_tag;
   logic [TIME_W-1:0]      finish_time;
   logic [COUNT_OUT_W-1:0] waiting_count;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, output busy_res, output running_tag,
                   output finish_time, output waiting_count, output status,
                   input ready);
   modport sink   (input valid, input busy_res, input running_tag,
                   input finish_time, input waiting_count, input status,
                   output ready);
endinterface

@@ src/srpt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module srpt_ram #(
   parameter  int WIDTH = 36,
   parameter  int DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/srpt_queue.sv @@
// Sorted wait queue engine: insert and pop sequencer over one RAM.
// Depends on srpt_pkg and srpt_ram.
module srpt_queue import srpt_pkg::*; #(
   parameter  int DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  qcmd_type         cmd,
   output qstat_type        stat,
   output logic [CNT_W-1:0] count
);

   typedef enum logic [7:0] {
      Q_IDLE      = 8'b0000_0001,
      Q_INS_SHIFT = 8'b0000_0010,
      Q_INS_PLACE = 8'b0000_0100,
      Q_POP_RDL   = 8'b0000_1000,
      Q_POP_LAST  = 8'b0001_0000,
      Q_POP_SCAN  = 8'b0010_0000,
      Q_POP_PLACE = 8'b0100_0000,
      Q_SPARE     = 8'b1000_0000
   } qstate_type;

   qstate_type       state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] n_ff, n_in;
   entry_type        item_ff, item_in;
   entry_type        head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   logic [$bits(entry_type)-1:0] rd_raw;
   logic             done;

   logic [IDX_W-1:0] ptr_m1, ptr_m2;
   logic [IDX_W:0]   ptr_p2, n_ext;

   assign ptr_m1 = ptr_ff - IDX_W'(1);
   assign ptr_m2 = ptr_m1 - IDX_W'(1);
   assign ptr_p2 = {1'b0, ptr_ff} + (IDX_W + 1)'(2);
   assign n_ext  = {1'b0, n_ff};
   assign rd_data = entry_type'(rd_raw);

   srpt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Accesses never hit an entry written in the same cycle:
   // reads run two places ahead of the write, and no new command is
   // taken until done.
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      n_in     = n_ff;
      item_in  = item_ff;
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = item_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      done     = 1'b0;

      unique case (state_ff)
         Q_IDLE: begin
            if (cmd.start) begin
               if (!cmd.pop) begin
                  item_in  = cmd.entry;
                  count_in = count_ff + CNT_W'(1);
                  ptr_in   = IDX_W'(count_ff);
                  if (count_ff == '0) begin
                     state_in = Q_INS_PLACE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                     state_in = Q_INS_SHIFT;
                  end
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  n_in     = IDX_W'(count_ff - CNT_W'(1));
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = Q_POP_RDL;
               end
            end
         end

         // rd_data holds entry ptr-1
         Q_INS_SHIFT: begin
            wr_en = 1'b1;
            if (item_ff.key < rd_data.key) begin
               wr_data = rd_data;
               ptr_in  = ptr_m1;
               if (ptr_m1 == '0) begin
                  state_in = Q_INS_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_m2;
               end
            end else begin
               done     = 1'b1;
               state_in = Q_IDLE;
            end
         end

         Q_INS_PLACE, Q_POP_PLACE: begin
            wr_en    = 1'b1;
            done     = 1'b1;
            state_in = Q_IDLE;
         end

         // rd_data holds the head
         Q_POP_RDL: begin
            head_in  = rd_data;
            state_in = Q_POP_LAST;
            if (n_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = n_ff;
            end
         end

         // rd_data holds the tail entry, which refills the front
         Q_POP_LAST: begin
            ptr_in  = '0;
            item_in = rd_data;
            if (n_ff == '0) begin
               done     = 1'b1;
               state_in = Q_IDLE;
            end else if (n_ff == IDX_W'(1)) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_data;
               done     = 1'b1;
               state_in = Q_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(1);
               state_in = Q_POP_SCAN;
            end
         end

         // rd_data holds entry ptr+1; tail moves back while its key is larger
         Q_POP_SCAN: begin
            wr_en = 1'b1;
            if (item_ff.key > rd_data.key) begin
               wr_data = rd_data;
               ptr_in  = ptr_ff + IDX_W'(1);
               if (ptr_p2 < n_ext) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_p2[IDX_W-1:0];
               end else begin
                  state_in = Q_POP_PLACE;
               end
            end else begin
               done     = 1'b1;
               state_in = Q_IDLE;
            end
         end

         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      ptr_ff  <= ptr_in;
      n_ff    <= n_in;
      item_ff <= item_in;
      head_ff <= head_in;
   end

   assign stat.done = done;
   assign stat.head = head_ff;
   assign count     = count_ff;

endmodule

@@ src/srpt_preemptive_scheduler.sv @@
// Top level of the preemptive shortest-remaining-time scheduler.
// Depends on srpt_pkg, srpt_chan_if, srpt_queue (and through it srpt_ram).
//
//   channel   dir   handshake          beat carries
//   req_bus   in    valid/ready        opcode, now, job_size, job_tag
//   rsp_bus   out   valid/ready        busy_res, running_tag, finish_time,
//                                      waiting_count, status
//
// An event that leaves the queue alone (idle arrival, overflow, idle completion, last
// completion) loads its result directly. An arrival that queues a job shifts the
// entries with larger keys up; a pop refills the front with the tail entry, which
// then moves back past smaller keys. Both go through the one read and one write port
// of the queue RAM. Reset clears control state only. A stalled rsp_bus blocks events
// once the result reg is full.
module srpt_preemptive_scheduler import srpt_pkg::*; #(
   parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic      clock,
   input  logic      reset,
   srpt_req_if.sink   req_bus,
   srpt_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WAIT = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic              run_busy_ff, run_busy_in;
   logic [TAG_W-1:0]  run_tag_ff, run_tag_in;
   logic [TIME_W-1:0] run_finish_ff, run_finish_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              pop_ff, pop_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_busy_ff, rsp_busy_in;
   logic [TAG_W-1:0]       rsp_tag_ff, rsp_tag_in;
   logic [TIME_W-1:0]      rsp_finish_ff, rsp_finish_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   status_type             rsp_status_ff, rsp_status_in;

   qcmd_type         cmd;
   qstat_type        stat;
   logic [CNT_W-1:0] count;

   logic              req_ready, accept, load;
   status_type        res_status;
   logic [TIME_W-1:0] size_ext, start_finish, rem_raw, rem, pop_finish;
   logic              late, keep_run, full;
   logic [KEY_W-1:0]  rem_sat;

   srpt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .count (count)
   );

   // Take a new event only with the queue engine idle and the output
   // register free or being emptied this cycle.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept    = req_bus.valid && req_ready;

   // Preemption decision on the arriving beat.
   assign size_ext     = TIME_W'(req_bus.job_size);
   assign start_finish = req_bus.now + size_ext;
   assign late         = run_finish_ff <= req_bus.now;
   assign rem_raw      = run_finish_ff - req_bus.now;
   assign rem          = late ? '0 : rem_raw;
   assign keep_run     = rem < size_ext;
   // stored remainder saturates; comparison above uses the full value
   assign rem_sat      = (rem > TIME_W'(REM_MAX)) ? REM_MAX : rem[KEY_W-1:0];
   assign full         = count >= CNT_W'(QUEUE_DEPTH);
   assign pop_finish   = now_ff + TIME_W'(stat.head.key);

   always_comb begin
      state_in      = state_ff;
      run_busy_in   = run_busy_ff;
      run_tag_in    = run_tag_ff;
      run_finish_in = run_finish_ff;
      now_in        = now_ff;
      pop_in        = pop_ff;
      cmd           = '0;
      load          = 1'b0;
      res_status    = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.opcode == OP_ARRIVE) begin
                  if (!run_busy_ff) begin
                     run_busy_in   = 1'b1;
                     run_tag_in    = req_bus.job_tag;
                     run_finish_in = start_finish;
                     load          = 1'b1;
                  end else if (full) begin
                     // dropped, even if it would have preempted
                     res_status = STATUS_OVERFLOW;
                     load       = 1'b1;
                  end else begin
                     cmd.start = 1'b1;
                     cmd.pop   = 1'b0;
                     pop_in    = 1'b0;
                     state_in  = ST_WAIT;
                     if (keep_run) begin
                        cmd.entry.key = req_bus.job_size;
                        cmd.entry.tag = req_bus.job_tag;
                     end else begin
                        // requeue the running job, new one runs
                        cmd.entry.key = rem_sat;
                        cmd.entry.tag = run_tag_ff;
                        run_tag_in    = req_bus.job_tag;
                        run_finish_in = start_finish;
                     end
                  end
               end else begin
                  if (!run_busy_ff) begin
                     res_status = STATUS_IDLE_DONE;
                     load       = 1'b1;
                  end else if (count == '0) begin
                     run_busy_in = 1'b0;
                     load        = 1'b1;
                  end else begin
                     cmd.start = 1'b1;
                     cmd.pop   = 1'b1;
                     now_in    = req_bus.now;
                     pop_in    = 1'b1;
                     state_in  = ST_WAIT;
                  end
               end
            end
         end

         ST_WAIT: begin
            if (stat.done) begin
               if (pop_ff) begin
                  run_tag_in    = stat.head.tag;
                  run_finish_in = pop_finish;
               end
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: the queue count is already final when a result loads.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_busy_in   = rsp_busy_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_busy_in   = run_busy_in;
         rsp_tag_in    = run_busy_in ? run_tag_in : '0;
         rsp_finish_in = run_busy_in ? run_finish_in : '0;
         rsp_count_in  = COUNT_OUT_W'(count);
         rsp_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_busy_ff   <= 1'b0;
         run_tag_ff    <= '0;
         run_finish_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_busy_ff   <= run_busy_in;
         run_tag_ff    <= run_tag_in;
         run_finish_ff <= run_finish_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      now_ff        <= now_in;
      pop_ff        <= pop_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_bus.ready         = req_ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.busy_res      = rsp_busy_ff;
   assign rsp_bus.running_tag   = rsp_tag_ff;
   assign rsp_bus.finish_time   = rsp_finish_ff;
   assign rsp_bus.waiting_count = rsp_count_ff;
   assign rsp_bus.status        = rsp_status_ff;

endmodule

@@ src/srpt_checker.sv @@
// Port-level assertions for the SRPT scheduler, bound to the top level.
// Depends on srpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srpt_checker import srpt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   busy_res,
   input logic [TAG_W-1:0]       running_tag,
   input logic [TIME_W-1:0]      finish_time,
   input logic [COUNT_OUT_W-1:0] waiting_count,
   input logic [STATUS_W-1:0]    status
);

   // stalled result beat holds
   `SRPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(running_tag) && $stable(finish_time) && $stable(waiting_count) && $stable(status), "stalled result changed")

   // single output register: no event taken while a result is stuck
   `SRPT_ASSERT_NOW(a_no_overrun, req_valid && req_ready, !rsp_valid || rsp_ready, "event accepted over a waiting result")

   // idle results carry no job
   `SRPT_ASSERT_NOW(a_idle_clear, rsp_valid && !busy_res, running_tag == '0 && finish_time == '0, "idle result with tag or finish time")

   // overflow only while busy, idle completion only while idle
   `SRPT_ASSERT_NOW(a_status_busy, rsp_valid && status != STATUS_OK, (status == STATUS_OVERFLOW && busy_res) || (status == STATUS_IDLE_DONE && !busy_res), "status inconsistent with busy")

endmodule

bind srpt_preemptive_scheduler srpt_checker u_srpt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .busy_res      (rsp_bus.busy_res),
   .running_tag   (rsp_bus.running_tag),
   .finish_time   (rsp_bus.finish_time),
   .waiting_count (rsp_bus.waiting_count),
   .status        (rsp_bus.status)
);

@@ bench/tb.sv @@
// Self-checking bench for srpt_preemptive_scheduler: a directed run, then random traffic.
// Depends on srpt_pkg and on the srpt_req_if / srpt_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import srpt_pkg::*;

   localparam int QDEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int RESET_CYCLES  = 3;
   // Longest event is a pop of a full queue.
   localparam int DRAIN_CYCLES  = 4 * QDEPTH;
   // No beat on either side for this long means the block is hung.
   localparam int WATCHDOG_MAX  = 4000;
   // Long receiver hold-off, started once during the queue fill phase.
   localparam int HOLD_AT_BEAT  = 200;
   localparam int HOLD_CYCLES   = 300;

   // One scheduler event as presented on req_bus.
   typedef struct packed {
      opcode_type        op;
      logic [TIME_W-1:0] at;
      logic [KEY_W-1:0]  size;
      logic [TAG_W-1:0]  tag;
   } sched_evt_type;

   // One result beat as expected on rsp_bus.
   typedef struct packed {
      logic                   busy;
      logic [TAG_W-1:0]       tag;
      logic [TIME_W-1:0]      finish;
      logic [COUNT_OUT_W-1:0] count;
      status_type             status;
   } sched_result_type;

   // Receiver stall modes.
   typedef enum logic [1:0] {
      RX_OPEN    = 2'd0,
      RX_PATTERN = 2'd1,
      RX_BUSY    = 2'd2,
      RX_SPARSE  = 2'd3
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   srpt_req_if req_bus ();
   srpt_rsp_if rsp_bus ();

   // Bench-side drive registers; known from time zero.
   logic          drv_valid = 1'b0;
   sched_evt_type drv_evt   = '0;
   logic          rsp_ready = 1'b0;

   assign req_bus.valid    = drv_valid;
   assign req_bus.opcode   = drv_evt.op;
   assign req_bus.now      = drv_evt.at;
   assign req_bus.job_size = drv_evt.size;
   assign req_bus.job_tag  = drv_evt.tag;
   assign rsp_bus.ready    = rsp_ready;

   srpt_preemptive_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sched_evt_type    pending_events[$];
   sched_result_type expected_results[$];
   int               errors = 0;

   // ------------------------------------------------------------------
   // Scheduler shadow: running job plus the sorted wait queue.
   // ------------------------------------------------------------------
   logic [KEY_W-1:0]  sh_keys[QDEPTH];
   logic [TAG_W-1:0]  sh_tags[QDEPTH];
   int                sh_count  = 0;
   logic              sh_busy   = 1'b0;
   logic [TAG_W-1:0]  sh_tag    = '0;
   logic [TIME_W-1:0] sh_finish = '0;

   // Insert behind any entries with the same key (stable order).
   function automatic void insert_sorted(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
      int i;
      i = sh_count;
      while (i > 0 && key < sh_keys[i-1]) begin
         sh_keys[i] = sh_keys[i-1];
         sh_tags[i] = sh_tags[i-1];
         i--;
      end
      sh_keys[i] = key;
      sh_tags[i] = tag;
      sh_count++;
   endfunction

   // Apply one accepted event to the shadow and return the beat it produces.
   function automatic sched_result_type schedule_step(sched_evt_type ev);
      sched_result_type  r;
      logic [TIME_W-1:0] rem;
      logic [KEY_W-1:0]  head_key;
      logic [KEY_W-1:0]  tk;
      logic [TAG_W-1:0]  tt;
      int                i;
      r.status = STATUS_OK;
      if (ev.op == OP_ARRIVE) begin
         if (!sh_busy) begin
            sh_busy   = 1'b1;
            sh_tag    = ev.tag;
            sh_finish = ev.at + ev.size;           // wraps mod 2^32
         end else if (sh_count >= QDEPTH) begin
            r.status = STATUS_OVERFLOW;            // dropped even if it would preempt
         end else begin
            // late clock counts as nothing left to run
            rem = (sh_finish > ev.at) ? sh_finish - ev.at : '0;
            if (rem < ev.size) begin
               insert_sorted(ev.size, ev.tag);
            end else begin
               // compare on full remainder, store saturated
               insert_sorted((rem > REM_MAX) ? REM_MAX : rem[KEY_W-1:0], sh_tag);
               sh_tag    = ev.tag;
               sh_finish = ev.at + ev.size;
            end
         end
      end else begin
         if (!sh_busy) begin
            r.status = STATUS_IDLE_DONE;
         end else if (sh_count == 0) begin
            sh_busy = 1'b0;
         end else begin
            head_key  = sh_keys[0];
            sh_tag    = sh_tags[0];
            sh_finish = ev.at + head_key;
            sh_count--;
            if (sh_count > 0) begin
               // tail to front, then sink while strictly larger than the next key
               sh_keys[0] = sh_keys[sh_count];
               sh_tags[0] = sh_tags[sh_count];
               i = 0;
               while (i + 1 < sh_count && sh_keys[i] > sh_keys[i+1]) begin
                  tk = sh_keys[i];
                  tt = sh_tags[i];
                  sh_keys[i]   = sh_keys[i+1];
                  sh_tags[i]   = sh_tags[i+1];
                  sh_keys[i+1] = tk;
                  sh_tags[i+1] = tt;
                  i++;
               end
            end
         end
      end
      r.busy   = sh_busy;
      r.tag    = sh_busy ? sh_tag : '0;
      r.finish = sh_busy ? sh_finish : '0;
      r.count  = sh_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_event(opcode_type op, logic [TIME_W-1:0] at,
                            logic [KEY_W-1:0] size, logic [TAG_W-1:0] tag);
      sched_evt_type ev;
      ev.op   = op;
      ev.at   = at;
      ev.size = size;
      ev.tag  = tag;
      pending_events.push_back(ev);
   endtask

   // Mostly tiny sizes so equal keys and reorders are common.
   function automatic logic [KEY_W-1:0] pick_size();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel < 6)
         return KEY_W'($urandom_range(1, 16));
      else if (sel == 6)
         return KEY_W'($urandom_range(1, 4096));
      else
         return KEY_W'($urandom_range(1, 20'hFFFFF));
   endfunction

   // Completion beats carry junk in the unused fields.
   task automatic add_random_event(logic [TIME_W-1:0] at, int arrive_pct);
      if ($urandom_range(0, 99) < arrive_pct)
         add_event(OP_ARRIVE, at, pick_size(), TAG_W'($urandom_range(0, 16'hFFFF)));
      else
         add_event(OP_COMPLETE, at, KEY_W'($urandom_range(0, 20'hFFFFF)),
                   TAG_W'($urandom_range(0, 16'hFFFF)));
   endtask

   // ------------------------------------------------------------------
   // Driver: bursts of beats with random gaps in between.
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_bus.ready)
            expected_results.push_back(schedule_step(drv_evt));
         if (!drv_valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               drv_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               drv_evt   <= pending_events.pop_front();
               drv_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  // long back-to-back stretch
                  burst_left = $urandom_range(40, 120);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(1, 8);
               end
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result beat, drives ready on its own pattern.
   // ------------------------------------------------------------------
   int               rsp_beats = 0;
   int               hold_left = 0;
   logic             held_off  = 1'b0;
   rx_mode_type      rx_mode   = RX_OPEN;
   int               mode_left = 0;
   logic [15:0]      stall_pat = 16'hFFFF;
   logic             nxt_ready;
   sched_result_type want;

   task automatic check_field(string fname, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            rsp_beats++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual tag %h finish %h",
                        $time, rsp_bus.running_tag, rsp_bus.finish_time);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("busy_res", 32'(want.busy), 32'(rsp_bus.busy_res));
               check_field("running_tag", 32'(want.tag), 32'(rsp_bus.running_tag));
               check_field("finish_time", want.finish, rsp_bus.finish_time);
               check_field("waiting_count", 32'(want.count), 32'(rsp_bus.waiting_count));
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
            end
         end

         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else if (!held_off && rsp_beats >= HOLD_AT_BEAT) begin
            // one long hold-off so the block backs up into req_bus
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            nxt_ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
               stall_pat = 16'($urandom_range(0, 16'hFFFF));
            end
            mode_left--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            case (rx_mode)
               RX_OPEN:    nxt_ready = 1'b1;
               RX_PATTERN: nxt_ready = stall_pat[0];
               RX_BUSY:    nxt_ready = ($urandom_range(0, 3) != 0);
               default:    nxt_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= nxt_ready;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: cycles with no beat on either channel.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((drv_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
            $display("srpt_preemptive_scheduler test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] t_now;
   int                sel;

   initial begin
      // Directed part.
      add_event(OP_COMPLETE, 32'd0, 20'hFFFFF, 16'hFFFF);     // completion while idle
      add_event(OP_ARRIVE,   32'd0, 20'd1, 16'h0000);          // idle start, size one, min tag
      add_event(OP_ARRIVE,   32'd0, 20'hFFFFF, 16'hFFFF);      // longer job queues
      add_event(OP_ARRIVE,   32'd5, 20'd10, 16'h1234);         // late clock, rem is zero
      add_event(OP_ARRIVE,   32'd5, 20'd0, 16'h00AA);          // zero size always preempts
      add_event(OP_COMPLETE, 32'd6, 20'd0, 16'h0000);          // pop, tail sinks back
      add_event(OP_ARRIVE,   32'd6, 20'd10, 16'h5555);         // equal key goes behind
      add_event(OP_ARRIVE,   32'd6, 20'd10, 16'h5556);
      add_event(OP_COMPLETE, 32'h0010_0000, 20'd0, 16'h0000);
      add_event(OP_ARRIVE,   32'd0, 20'd5, 16'h0F0F);          // long remainder saturates
      add_event(OP_ARRIVE,   32'd3, 20'd2, 16'h0F10);          // remainder equals size
      add_event(OP_ARRIVE,   32'd3, 20'd3, 16'h0F11);          // running has less left, new job queues
      repeat (8) add_event(OP_COMPLETE, 32'd50, 20'd0, 16'h0000); // drain past idle
      add_event(OP_ARRIVE,   32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF); // finish wraps
      add_event(OP_ARRIVE,   32'hFFFF_FFF0, 20'd20, 16'h8000);
      add_event(OP_ARRIVE,   32'hFFFF_FFF0, 20'd20, 16'h8001);
      add_event(OP_COMPLETE, 32'hFFFF_FFFF, 20'd0, 16'h0000);  // completion clock wraps
      add_event(OP_COMPLETE, 32'hFFFF_FFFF, 20'd0, 16'h0000);
      add_event(OP_COMPLETE, 32'hFFFF_FFFF, 20'd0, 16'h0000);

      // Random mix with a steadily advancing clock.
      t_now = $urandom_range(0, 1000);
      repeat (150) begin
         t_now += $urandom_range(0, 40);
         add_random_event(t_now, 55);
      end

      // Fill the queue to overflow, then drain it and beyond.
      repeat (135) begin
         t_now += $urandom_range(0, 3);
         add_event(OP_ARRIVE, t_now, pick_size(), TAG_W'($urandom_range(0, 16'hFFFF)));
      end
      repeat (140) begin
         t_now += $urandom_range(0, 5);
         add_event(OP_COMPLETE, t_now, KEY_W'($urandom_range(0, 20'hFFFFF)),
                   TAG_W'($urandom_range(0, 16'hFFFF)));
      end

      // Clock jumps: anywhere, near wrap, and backward.
      repeat (120) begin
         sel = $urandom_range(0, 19);
         if (sel < 2)
            t_now = $urandom;
         else if (sel < 4)
            t_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         else if (sel == 4)
            t_now -= $urandom_range(0, 22'h3FFFFF);
         else
            t_now += $urandom_range(0, 60);
         add_random_event(t_now, 60);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come back.
      @(posedge clock);
      while (pending_events.size() != 0 || drv_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_results.size() == 0) begin
         $display("srpt_preemptive_scheduler test passed");
      end else begin
         $display("srpt_preemptive_scheduler test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/srpt_pkg.sv
src/srpt_chan_if.sv
src/srpt_ram.sv
src/srpt_queue.sv
src/srpt_preemptive_scheduler.sv
src/srpt_checker.sv
bench/tb.sv
